@@ hw/rtl/ismc_pkg.sv @@
// Package for the interrupt status and mask controller.
// Holds item codes, register select codes, summary constants and shared types.
// No dependencies.
package ismc_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned NUM_MASKS = 9;
	localparam int unsigned MASK_IDX_W = $clog2(NUM_MASKS);

	typedef enum logic [1:0] {
		MODE_RAISE  = 2'd0,
		MODE_CANCEL = 2'd1,
		MODE_WRITE  = 2'd2,
		MODE_READ   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CAT_NORMAL   = 2'd0,
		CAT_EXTERNAL = 2'd1,
		CAT_ERROR    = 2'd2,
		CAT_NONE     = 2'd3
	} category_t;

	// register select codes
	localparam logic [3:0] SEL_NORMAL     = 4'd0;
	localparam logic [3:0] SEL_EXTERNAL   = 4'd1;
	localparam logic [3:0] SEL_ERROR      = 4'd2;
	localparam logic [3:0] SEL_MASK_FIRST = 4'd3;
	localparam logic [3:0] SEL_MASK_LAST  = 4'd11;

	localparam logic [WORD_W-1:0] SUMMARY_LOW_MASK = 32'h3FFF_FFFF;
	localparam logic [WORD_W-1:0] SUMMARY_EXT_BIT  = 32'h4000_0000;
	localparam logic [WORD_W-1:0] SUMMARY_ERR_BIT  = 32'h8000_0000;

	typedef struct packed {
		mode_t             mode;
		category_t         category;
		logic [4:0]        bit_idx;
		logic [3:0]        sel;
		logic [WORD_W-1:0] data;
	} item_t;

	typedef struct packed {
		logic l2;
		logic l4;
		logic l6;
	} pending_t;

endpackage

@@ hw/rtl/ismc_regs.sv @@
// Status and mask register file with next-state and level-pending logic.
// Depends on ismc_pkg.
module ismc_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              commit,
	input  ismc_pkg::item_t                   item,
	output logic [ismc_pkg::WORD_W-1:0]       rd_data,
	output ismc_pkg::pending_t                pending
);
	import ismc_pkg::*;

	logic [WORD_W-1:0] normal_q;
	logic [WORD_W-1:0] external_q;
	logic [WORD_W-1:0] error_q;
	logic [WORD_W-1:0] mask_q   [NUM_MASKS];

	logic [WORD_W-1:0] nxt_normal;
	logic [WORD_W-1:0] nxt_external;
	logic [WORD_W-1:0] nxt_error;
	logic [WORD_W-1:0] nxt_mask [NUM_MASKS];

	logic [WORD_W-1:0]     bit_dec;
	logic [3:0]            sel_off;
	logic [MASK_IDX_W-1:0] mask_idx;
	logic                  mask_sel;
	logic [2:0]            lvl_hit;

	assign bit_dec  = {{(WORD_W-1){1'b0}}, 1'b1} << item.bit_idx;
	assign sel_off  = item.sel - SEL_MASK_FIRST;
	assign mask_idx = sel_off[MASK_IDX_W-1:0];
	assign mask_sel = (item.sel >= SEL_MASK_FIRST) && (item.sel <= SEL_MASK_LAST);

	always_comb begin
		nxt_normal   = normal_q;
		nxt_external = external_q;
		nxt_error    = error_q;
		nxt_mask     = mask_q;
		unique case (item.mode)
			MODE_RAISE: begin
				case (item.category)
					CAT_NORMAL:   nxt_normal   = normal_q | bit_dec;
					CAT_EXTERNAL: nxt_external = external_q | bit_dec;
					CAT_ERROR:    nxt_error    = error_q | bit_dec;
					default: ;
				endcase
			end
			MODE_CANCEL: nxt_external = external_q & ~bit_dec;
			MODE_WRITE: begin
				// external status is not writable
				if (item.sel == SEL_NORMAL) begin
					nxt_normal = normal_q & ~item.data;
				end else if (item.sel == SEL_ERROR) begin
					nxt_error = error_q & ~item.data;
				end else if (mask_sel) begin
					nxt_mask[mask_idx] = item.data;
				end
			end
			MODE_READ: ;
			default: ;
		endcase
	end

	// reads never change state, so the stored words are read directly
	always_comb begin
		rd_data = '0;
		if (item.mode == MODE_READ) begin
			if (item.sel == SEL_NORMAL) begin
				rd_data = normal_q & SUMMARY_LOW_MASK;
				if (|external_q) rd_data = rd_data | SUMMARY_EXT_BIT;
				if (|error_q)    rd_data = rd_data | SUMMARY_ERR_BIT;
			end else if (item.sel == SEL_EXTERNAL) begin
				rd_data = external_q;
			end else if (item.sel == SEL_ERROR) begin
				rd_data = error_q;
			end else if (mask_sel) begin
				rd_data = mask_q[mask_idx];
			end
		end
	end

	// pending lines follow the state after this item
	always_comb begin
		for (int lvl = 0; lvl < 3; lvl++) begin
			lvl_hit[lvl] = |((nxt_normal   & nxt_mask[3*lvl])     |
			                 (nxt_external & nxt_mask[3*lvl + 1]) |
			                 (nxt_error    & nxt_mask[3*lvl + 2]));
		end
		pending.l2 = lvl_hit[0];
		pending.l4 = lvl_hit[1];
		pending.l6 = lvl_hit[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_q   <= '0;
			external_q <= '0;
			error_q    <= '0;
			for (int i = 0; i < NUM_MASKS; i++) begin
				mask_q[i] <= '0;
			end
		end else if (commit) begin
			normal_q   <= nxt_normal;
			external_q <= nxt_external;
			error_q    <= nxt_error;
			mask_q     <= nxt_mask;
		end
	end

endmodule

@@ hw/rtl/interrupt_status_mask_controller.sv @@
// Interrupt status and mask controller, top level.
// Pipeline: an accepted item is held in the input reg, then its result in the result reg.
// Throughput: one item per cycle while the result side is not stalled; the next item is taken while a result waits.
// The combinational update and OR reduction in ismc_regs sets the pace.
// Reset: all status and mask words clear to zero, both pipeline stages empty.
// Depends on ismc_pkg and ismc_regs.
module interrupt_status_mask_controller (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [1:0]  event_category,
	input  logic [4:0]  event_bit,
	input  logic [3:0]  reg_select,
	input  logic [31:0] write_data,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic        level2_pending,
	output logic        level4_pending,
	output logic        level6_pending
);
	import ismc_pkg::*;

	// Stage 1: registered input item
	logic     valid_s1;
	item_t    item_s1;
	item_t    item_in;

	// Result register
	logic              out_valid_q;
	logic [WORD_W-1:0] rd_q;
	pending_t          pend_q;

	logic              take_in;
	logic              advance;
	logic [WORD_W-1:0] rd_data;
	pending_t          pending;

	assign item_in.mode     = mode_t'(mode);
	assign item_in.category = category_t'(event_category);
	assign item_in.bit_idx  = event_bit;
	assign item_in.sel      = reg_select;
	assign item_in.data     = write_data;

	// The stage-1 item moves on (and commits its state update) whenever the
	// result register is empty or being emptied this cycle.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	// Stage 1 can refill in the same cycle it drains, so back-to-back items flow.
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= item_in;
		end
	end

	// Status/mask state is only written when the item leaves stage 1, so a
	// stalled item never applies its update twice.
	ismc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.commit  (advance),
		.item    (item_s1),
		.rd_data (rd_data),
		.pending (pending)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rd_q   <= rd_data;
			pend_q <= pending;
		end
	end

	assign out_valid      = out_valid_q;
	assign read_data      = rd_q;
	assign level2_pending = pend_q.l2;
	assign level4_pending = pend_q.l4;
	assign level6_pending = pend_q.l6;

endmodule

@@ hw/rtl/ismc_checker.sv @@
// Port-level checker for the interrupt status and mask controller, with bind.
// Depends on interrupt_status_mask_controller ports only.
module ismc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] read_data,
	input logic        level2_pending,
	input logic        level4_pending,
	input logic        level6_pending
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data) &&
			$stable(level2_pending) && $stable(level4_pending) && $stable(level6_pending))
		else $error("result changed while stalled");

	// input only backs up when the result side is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with result side free");

	// a fresh result needs a matching item taken in ahead of it through stage 1
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without matching item");

endmodule

bind interrupt_status_mask_controller ismc_checker u_ismc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.read_data      (read_data),
	.level2_pending (level2_pending),
	.level4_pending (level4_pending),
	.level6_pending (level6_pending)
);
